>>> hw/rtl/euq_pkg.sv
// Shared types, constants and helper functions for the Euler-to-quaternion pipeline.
// Holds the arctangent table and the elaboration-time CORDIC gain calculation.
// No dependencies.
package euq_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 31;

    // CORDIC datapath width, Q2.30 with two guard bits
    localparam int ZW = 34;
    // sine, cosine and product results, Q1.30
    localparam int QW = 32;
    // products of two Q30 values
    localparam int PW = 64;
    // sum of two Q30 values
    localparam int SW = QW + 1;
    localparam int AW = 16;
    localparam int OW = 16;

    // pipeline: fold, CORDIC stages, sin/cos, mult, round, mult, round, sum, output
    localparam int NUM_ST = CORDIC_STAGES + 8;

    typedef logic signed [ZW-1:0] cval_t;
    typedef logic signed [QW-1:0] q30_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [OW-1:0] q14_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
        logic  neg;
    } lane_t;

    localparam cval_t PI_Q30      = 34'sd3373259426;
    localparam cval_t HALF_PI_Q30 = 34'sd1686629713;
    localparam q14_t  ONE_Q14     = 16'sd16384;

    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001
    };

    function automatic cval_t atan_step(input int i);
        cval_t r;
        r = '0;
        if (i < ATAN_ENTRIES)
        begin
            r = cval_t'(ATAN_Q30[i]);
        end
        return r;
    endfunction

    // round(2^60 / floor(sqrt(prod(1 + 2^-2i)))) with the product in Q60
    function automatic cval_t cordic_inv_gain();
        longint unsigned p;
        longint unsigned n;
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned quo;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            p = p + (p >> (2 * i));
        end
        n    = p;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (bitv > n)
            begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++)
        begin
            if (bitv != 64'd0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        if (res == 64'd0)
        begin
            res = 64'd1;
        end
        num = (64'd1 << 60) + (res >> 1);
        rem = 64'd0;
        quo = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | {63'd0, num[b]};
            if (rem >= res)
            begin
                rem    = rem - res;
                quo[b] = 1'b1;
            end
        end
        return cval_t'(quo[ZW-1:0]);
    endfunction

    localparam cval_t INV_GAIN_Q30 = cordic_inv_gain();

    // Q60 product back to Q30, round half up
    function automatic q30_t rnd30(input prod_t p);
        prod_t t;
        t = (p + 64'sd536870912) >>> 30;
        return t[QW-1:0];
    endfunction

    // Q30 sum to Q14 with saturation to +-1.0
    function automatic q14_t to_q14(input sum_t v);
        logic signed [SW:0] t;
        q14_t r;
        t = ($signed({v[SW-1], v}) + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
        begin
            r = ONE_Q14;
        end
        else if (t < -34'sd16384)
        begin
            r = -ONE_Q14;
        end
        else
        begin
            r = t[OW-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/euler_to_quaternion.sv
// Euler angles (ZYX, Q3.13 radians) to unit quaternion (Q1.14), fully pipelined.
// Three CORDIC lanes for the half-angle sine/cosine, then two multiply/round rounds.
// Depends on euq_pkg.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, roll/pitch/yaw_angle  | in
//  output   | out_valid, out_stall, quat_x/y/z/w        | out
//
// One request per cycle while the output is not stalled; the pipeline has one
// register per CORDIC iteration plus fold, sine/cosine, two multiply, two round,
// sum and output stages.
// Reset clears the valid bits only; payload registers are not reset.
// Each stage holds while it is full and the stage after it holds, so empty slots fill
// while the output is stalled; in_stall rises only when every stage holds a request.
module euler_to_quaternion
    import euq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic signed [AW-1:0] roll_angle,
    input  logic signed [AW-1:0] pitch_angle,
    input  logic signed [AW-1:0] yaw_angle,
    output logic       out_valid,
    input  logic       out_stall,
    output logic signed [OW-1:0] quat_x,
    output logic signed [OW-1:0] quat_y,
    output logic signed [OW-1:0] quat_z,
    output logic signed [OW-1:0] quat_w
);

    localparam int ST_SC  = CORDIC_STAGES + 1;
    localparam int ST_M1  = CORDIC_STAGES + 2;
    localparam int ST_R1  = CORDIC_STAGES + 3;
    localparam int ST_M2  = CORDIC_STAGES + 4;
    localparam int ST_R2  = CORDIC_STAGES + 5;
    localparam int ST_SUM = CORDIC_STAGES + 6;
    localparam int ST_OUT = CORDIC_STAGES + 7;

    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] vld_next;
    logic [NUM_ST:0]   rdy;

    // ---------------------------------------------------------------- flow control
    always_comb
    begin
        rdy[NUM_ST] = !out_stall;
        for (int k = NUM_ST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign vld_next = (rdy[NUM_ST-1:0] & {vld_reg[NUM_ST-2:0], in_valid})
                    | (~rdy[NUM_ST-1:0] & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[ST_OUT];

    // ---------------------------------------------------------------- fold and CORDIC
    // lane 0 roll, lane 1 pitch, lane 2 yaw
    lane_t cord_reg  [0:CORDIC_STAGES][3];
    lane_t cord_next [0:CORDIC_STAGES][3];
    logic signed [AW-1:0] ang [3];

    assign ang[0] = roll_angle;
    assign ang[1] = pitch_angle;
    assign ang[2] = yaw_angle;

    for (genvar l = 0; l < 3; l++)
    begin : g_fold
        cval_t z0;
        assign z0 = {{2{ang[l][AW-1]}}, ang[l], 16'b0};

        // move half angles outside +-pi/2 by pi toward zero, negate the result later
        always_comb
        begin
            cord_next[0][l].x   = INV_GAIN_Q30;
            cord_next[0][l].y   = '0;
            cord_next[0][l].z   = z0;
            cord_next[0][l].neg = 1'b0;
            if (z0 > HALF_PI_Q30)
            begin
                cord_next[0][l].z   = z0 - PI_Q30;
                cord_next[0][l].neg = 1'b1;
            end
            else if (z0 < -HALF_PI_Q30)
            begin
                cord_next[0][l].z   = z0 + PI_Q30;
                cord_next[0][l].neg = 1'b1;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            localparam cval_t STEP = atan_step(i);
            cval_t dx;
            cval_t dy;
            assign dx = cord_reg[i][l].y >>> i;
            assign dy = cord_reg[i][l].x >>> i;

            always_comb
            begin
                cord_next[i+1][l].neg = cord_reg[i][l].neg;
                if (!cord_reg[i][l].z[ZW-1])
                begin
                    cord_next[i+1][l].x = cord_reg[i][l].x - dx;
                    cord_next[i+1][l].y = cord_reg[i][l].y + dy;
                    cord_next[i+1][l].z = cord_reg[i][l].z - STEP;
                end
                else
                begin
                    cord_next[i+1][l].x = cord_reg[i][l].x + dx;
                    cord_next[i+1][l].y = cord_reg[i][l].y - dy;
                    cord_next[i+1][l].z = cord_reg[i][l].z + STEP;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= CORDIC_STAGES; k++)
        begin
            if (rdy[k])
            begin
                cord_reg[k] <= cord_next[k];
            end
        end
    end

    // ---------------------------------------------------------------- sine and cosine
    q30_t s_reg [3];
    q30_t c_reg [3];
    q30_t s_next [3];
    q30_t c_next [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (cord_reg[CORDIC_STAGES][l].neg)
            begin
                s_next[l] = q30_t'(-cord_reg[CORDIC_STAGES][l].y);
                c_next[l] = q30_t'(-cord_reg[CORDIC_STAGES][l].x);
            end
            else
            begin
                s_next[l] = cord_reg[CORDIC_STAGES][l].y[QW-1:0];
                c_next[l] = cord_reg[CORDIC_STAGES][l].x[QW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SC])
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
    end

    // ---------------------------------------------------------------- pitch x yaw
    prod_t p1_reg [4];
    prod_t p1_next [4];
    q30_t  sr1_reg, cr1_reg;

    // cp*cy, sp*sy, sp*cy, cp*sy
    always_comb
    begin
        p1_next[0] = PW'(c_reg[1]) * PW'(c_reg[2]);
        p1_next[1] = PW'(s_reg[1]) * PW'(s_reg[2]);
        p1_next[2] = PW'(s_reg[1]) * PW'(c_reg[2]);
        p1_next[3] = PW'(c_reg[1]) * PW'(s_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_M1])
        begin
            p1_reg  <= p1_next;
            sr1_reg <= s_reg[0];
            cr1_reg <= c_reg[0];
        end
    end

    q30_t r1_reg [4];
    q30_t sr2_reg, cr2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_R1])
        begin
            for (int k = 0; k < 4; k++)
            begin
                r1_reg[k] <= rnd30(p1_reg[k]);
            end
            sr2_reg <= sr1_reg;
            cr2_reg <= cr1_reg;
        end
    end

    // ---------------------------------------------------------------- roll x (pitch x yaw)
    prod_t p2_reg [8];
    prod_t p2_next [8];

    always_comb
    begin
        p2_next[0] = PW'(sr2_reg) * PW'(r1_reg[0]);
        p2_next[1] = PW'(cr2_reg) * PW'(r1_reg[1]);
        p2_next[2] = PW'(cr2_reg) * PW'(r1_reg[2]);
        p2_next[3] = PW'(sr2_reg) * PW'(r1_reg[3]);
        p2_next[4] = PW'(cr2_reg) * PW'(r1_reg[3]);
        p2_next[5] = PW'(sr2_reg) * PW'(r1_reg[2]);
        p2_next[6] = PW'(cr2_reg) * PW'(r1_reg[0]);
        p2_next[7] = PW'(sr2_reg) * PW'(r1_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_M2])
        begin
            p2_reg <= p2_next;
        end
    end

    q30_t r2_reg [8];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_R2])
        begin
            for (int k = 0; k < 8; k++)
            begin
                r2_reg[k] <= rnd30(p2_reg[k]);
            end
        end
    end

    // ---------------------------------------------------------------- combine and saturate
    sum_t sum_reg [4];
    sum_t sum_next [4];

    always_comb
    begin
        sum_next[0] = SW'(r2_reg[0]) - SW'(r2_reg[1]);
        sum_next[1] = SW'(r2_reg[2]) + SW'(r2_reg[3]);
        sum_next[2] = SW'(r2_reg[4]) - SW'(r2_reg[5]);
        sum_next[3] = SW'(r2_reg[6]) + SW'(r2_reg[7]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    q14_t q_reg [4];

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
        begin
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= to_q14(sum_reg[k]);
            end
        end
    end

    assign quat_x = q_reg[0];
    assign quat_y = q_reg[1];
    assign quat_z = q_reg[2];
    assign quat_w = q_reg[3];

endmodule

>>> hw/rtl/euq_checker.sv
// Port-level checks for euler_to_quaternion, attached by bind.
// Depends on euq_pkg and the top-level port list.
module euq_checker
    import euq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic signed [OW-1:0] quat_x,
    input logic signed [OW-1:0] quat_y,
    input logic signed [OW-1:0] quat_z,
    input logic signed [OW-1:0] quat_w
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(quat_x) && $stable(quat_y)
                                   && $stable(quat_z) && $stable(quat_w))
        else $error("stalled result changed");

    // back-pressure reaches the input only when the output is full and stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipeline");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_x >= -ONE_Q14 && quat_x <= ONE_Q14
                   && quat_y >= -ONE_Q14 && quat_y <= ONE_Q14
                   && quat_z >= -ONE_Q14 && quat_z <= ONE_Q14
                   && quat_w >= -ONE_Q14 && quat_w <= ONE_Q14)
        else $error("quaternion component outside +-1.0");

endmodule

bind euler_to_quaternion euq_checker u_euq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w)
);
